// File: sv/vgmcse_pkg.sv
// ----------------------------------------------------------------------------
// vgmcse_pkg
// Shared types and constants of the VGM command stream encoder.
// ----------------------------------------------------------------------------
package vgmcse_pkg;

  // Widths of the pending delay and of the sample counters.
  localparam int unsigned PendW   = 24;
  localparam int unsigned SampleW = 32;

  // Stream packing.
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 72;

  // Wait, end and write command codes of the command stream.
  localparam logic [7:0] CmdWait      = 8'h61;
  localparam logic [7:0] CmdWaitShort = 8'h70;
  localparam logic [7:0] CmdEnd       = 8'h66;
  localparam logic [7:0] CmdWide      = 8'hE1;
  localparam logic [7:0] CmdShort     = 8'h54;

  localparam int unsigned FullWait     = 65535;
  localparam int unsigned ShortWaitMax = 16;
  localparam int unsigned Divisor      = 10;

  localparam int unsigned DefMaxFullWaits = 16;

  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindDelay = 2'd1,
    KindLoop  = 2'd2,
    KindStop  = 2'd3
  } kind_e;

endpackage

// File: sv/vgmcse_div10.sv
// ----------------------------------------------------------------------------
// vgmcse_div10
// Divider by ten through reciprocal multiplication: the quotient is registered
// on start and the remainder is registered from it while busy is high.
// ----------------------------------------------------------------------------
module vgmcse_div10 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [vgmcse_pkg::PendW-1:0]   dividend_i,
  output logic                           busy_o,
  output logic [vgmcse_pkg::PendW-1:0]   quotient_o,
  output logic [3:0]                     remainder_o
);

  localparam int unsigned PendW = vgmcse_pkg::PendW;
  localparam int unsigned Shift = PendW + 4;
  localparam int unsigned ProdW = 2 * PendW + 1;
  localparam logic [PendW:0] Magic =
    (PendW + 1)'(((64'd1 << Shift) + 64'(vgmcse_pkg::Divisor) - 64'd1)
                 / 64'(vgmcse_pkg::Divisor));

  logic [ProdW-1:0] product;
  logic [PendW-1:0] quo_q;
  logic [3:0]       dvd_lo_q;
  logic [3:0]       rem_q;
  logic [3:0]       ten_lo;
  logic             busy_q;

  assign product = ProdW'(dividend_i) * ProdW'(Magic);

  // The remainder is below ten, so the low four bits of x - 10*q give it.
  assign ten_lo = {quo_q[0], 3'b000} + {quo_q[2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q    <= PendW'(product >> Shift);
      dvd_lo_q <= dividend_i[3:0];
    end
    if (busy_q) begin
      rem_q <= dvd_lo_q - ten_lo;
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: sv/vgm_command_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_encoder_top
// Encodes chip register writes and delays into a VGM command byte stream.
// ----------------------------------------------------------------------------
// A delay transaction is absorbed while idle and produces no output. A
// write, loop-mark or stop transaction first divides the pending delay by ten
// in a reciprocal divider, decides the flush in S_DECIDE, then emits one byte
// per cycle while the master side accepts it: each full wait is three bytes
// from a shared 65535 subtract-and-compare unit, the full-wait phase ends in
// a state that emits nothing, and the S_REM state also emits nothing when no
// remainder wait is sent. A loop mark sends no body bytes.
// The slave side is not ready until the item's last byte is loaded into the
// output register; tlast marks that byte, and tuser marks the end byte that
// carries the total and loop sample counts.
// ----------------------------------------------------------------------------
module vgm_command_stream_encoder_top #(
  parameter int unsigned MAX_FULL_WAITS = vgmcse_pkg::DefMaxFullWaits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // command[7:0], port[15:8], reg_req[31:16], value[47:32], delay_tenths[79:48]
  input  logic [vgmcse_pkg::InDataW-1:0]    s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]                        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_byte[7:0], total_samples[39:8], loop_samples[71:40]
  output logic [vgmcse_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  // end_of_stream
  output logic                              m_axis_tuser_o
);

  localparam int unsigned PendW   = vgmcse_pkg::PendW;
  localparam int unsigned SampleW = vgmcse_pkg::SampleW;
  localparam logic [PendW-1:0] MaxTenths =
    PendW'((MAX_FULL_WAITS * vgmcse_pkg::FullWait + vgmcse_pkg::FullWait - 1)
           * vgmcse_pkg::Divisor + vgmcse_pkg::Divisor - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_DECIDE = 6'b000100,
    S_FULL   = 6'b001000,
    S_REM    = 6'b010000,
    S_BODY   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [PendW-1:0]   pending_q, pending_d;
  logic [SampleW-1:0] sample_total_q, sample_total_d;
  logic [SampleW-1:0] loop_start_q, loop_start_d;
  logic [PendW-1:0]   work_q, work_d;
  logic [2:0]         idx_q, idx_d;

  vgmcse_pkg::kind_e kind_q;
  logic [7:0]        cmd_q, port_q;
  logic [15:0]       reg_q, val_q;

  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q, out_eos_q;
  logic [SampleW-1:0]  out_total_q, out_loop_q;

  logic               in_accept;
  vgmcse_pkg::kind_e  in_kind;
  logic [31:0]        in_delay;
  logic [31:0]        headroom;

  logic               div_start, div_busy;
  logic [PendW-1:0]   div_quo;
  logic [3:0]         div_rem;

  logic               can_emit, emit, emit_last, emit_eos;
  logic [7:0]         emit_byte;

  logic               did_flush;
  logic [SampleW-1:0] new_total;
  logic [PendW:0]     wait_diff;
  logic               has_full;
  logic [1:0]         rem_len;
  logic               rem_end;
  logic [2:0]         body_len;
  logic               body_end;
  logic [7:0]         body_byte;
  logic               is_loop;

  assign in_kind   = vgmcse_pkg::kind_e'(s_axis_tuser_i);
  assign in_delay  = s_axis_tdata_i[79:48];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign headroom  = {8'd0, MaxTenths - pending_q};
  assign div_start = in_accept && (in_kind != vgmcse_pkg::KindDelay);
  assign can_emit  = !out_valid_q || m_axis_tready_i;
  assign is_loop   = (kind_q == vgmcse_pkg::KindLoop);

  vgmcse_div10 u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (pending_q),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign did_flush = (div_quo >= PendW'(2));
  assign new_total = sample_total_q + SampleW'(div_quo);

  // Shared subtract-and-compare unit for the full 65535-sample waits.
  assign wait_diff = {1'b0, work_q} - (PendW + 1)'(vgmcse_pkg::FullWait);
  assign has_full  = !wait_diff[PendW];

  always_comb begin
    if (work_q > PendW'(vgmcse_pkg::ShortWaitMax)) begin
      rem_len = 2'd3;
    end else if (work_q != '0) begin
      rem_len = 2'd1;
    end else begin
      rem_len = 2'd0;
    end
  end
  assign rem_end = (idx_q == 3'(rem_len) - 3'd1);

  always_comb begin
    if (kind_q == vgmcse_pkg::KindStop) begin
      body_len = 3'd1;
    end else if (cmd_q == vgmcse_pkg::CmdWide) begin
      body_len = 3'd5;
    end else if (cmd_q == vgmcse_pkg::CmdShort) begin
      body_len = 3'd3;
    end else begin
      body_len = 3'd4;
    end
  end
  assign body_end = (idx_q == body_len - 3'd1);

  always_comb begin
    body_byte = cmd_q;
    if (kind_q == vgmcse_pkg::KindStop) begin
      body_byte = vgmcse_pkg::CmdEnd;
    end else if (cmd_q == vgmcse_pkg::CmdWide) begin
      case (idx_q)
        3'd0:    body_byte = cmd_q;
        3'd1:    body_byte = reg_q[15:8];
        3'd2:    body_byte = reg_q[7:0];
        3'd3:    body_byte = val_q[15:8];
        3'd4:    body_byte = val_q[7:0];
        default: body_byte = cmd_q;
      endcase
    end else if (cmd_q == vgmcse_pkg::CmdShort) begin
      case (idx_q)
        3'd0:    body_byte = cmd_q;
        3'd1:    body_byte = reg_q[7:0];
        3'd2:    body_byte = val_q[7:0];
        default: body_byte = cmd_q;
      endcase
    end else begin
      case (idx_q)
        3'd0:    body_byte = cmd_q;
        3'd1:    body_byte = port_q;
        3'd2:    body_byte = reg_q[7:0];
        3'd3:    body_byte = val_q[7:0];
        default: body_byte = cmd_q;
      endcase
    end
  end

  always_comb begin
    state_d        = state_q;
    pending_d      = pending_q;
    sample_total_d = sample_total_q;
    loop_start_d   = loop_start_q;
    work_d         = work_q;
    idx_d          = idx_q;
    emit           = 1'b0;
    emit_byte      = vgmcse_pkg::CmdWait;
    emit_last      = 1'b0;
    emit_eos       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_kind == vgmcse_pkg::KindDelay) begin
            if (in_delay >= headroom) begin
              pending_d = MaxTenths;
            end else begin
              pending_d = pending_q + in_delay[PendW-1:0];
            end
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_d   = '0;
        state_d = S_FULL;
        if (did_flush) begin
          sample_total_d = new_total;
          work_d         = div_quo;
          pending_d      = (kind_q == vgmcse_pkg::KindStop) ? '0 : PendW'(div_rem);
        end else begin
          work_d = '0;
        end
        if (is_loop) begin
          loop_start_d = did_flush ? new_total : sample_total_q;
        end
      end
      S_FULL: begin
        if (!has_full) begin
          state_d = S_REM;
        end else if (can_emit) begin
          emit = 1'b1;
          emit_byte = (idx_q == 3'd0) ? vgmcse_pkg::CmdWait : 8'hFF;
          emit_last = is_loop && (idx_q == 3'd2) && (wait_diff[PendW-1:0] == '0);
          if (idx_q == 3'd2) begin
            idx_d  = '0;
            work_d = wait_diff[PendW-1:0];
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      S_REM: begin
        if (rem_len == 2'd0) begin
          state_d = is_loop ? S_IDLE : S_BODY;
        end else if (can_emit) begin
          emit = 1'b1;
          if (rem_len == 2'd1) begin
            emit_byte = 8'(vgmcse_pkg::CmdWaitShort + work_q[7:0] - 8'd1);
          end else begin
            case (idx_q)
              3'd0:    emit_byte = vgmcse_pkg::CmdWait;
              3'd1:    emit_byte = work_q[7:0];
              3'd2:    emit_byte = work_q[15:8];
              default: emit_byte = vgmcse_pkg::CmdWait;
            endcase
          end
          emit_last = is_loop && rem_end;
          if (rem_end) begin
            idx_d   = '0;
            state_d = is_loop ? S_IDLE : S_BODY;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      S_BODY: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = body_byte;
          emit_last = body_end;
          emit_eos  = (kind_q == vgmcse_pkg::KindStop);
          if (body_end) begin
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pending_q      <= '0;
      sample_total_q <= '0;
      loop_start_q   <= '0;
      idx_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      pending_q      <= pending_d;
      sample_total_q <= sample_total_d;
      loop_start_q   <= loop_start_d;
      idx_q          <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (in_accept) begin
      kind_q <= in_kind;
      cmd_q  <= s_axis_tdata_i[7:0];
      port_q <= s_axis_tdata_i[15:8];
      reg_q  <= s_axis_tdata_i[31:16];
      val_q  <= s_axis_tdata_i[47:32];
    end
    if (emit) begin
      out_byte_q  <= emit_byte;
      out_last_q  <= emit_last;
      out_eos_q   <= emit_eos;
      out_total_q <= emit_eos ? sample_total_q : '0;
      if (emit_eos && (loop_start_q != '0)) begin
        out_loop_q <= sample_total_q - loop_start_q;
      end else begin
        out_loop_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_loop_q, out_total_q, out_byte_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_eos_q;

  // The pending delay never climbs past the saturation point.
  a_pending_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= MaxTenths)
    else $error("pending delay above saturation");

  // The end byte is always the last byte of its item and carries the end code.
  a_end_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tlast_o && (m_axis_tdata_o[7:0] == vgmcse_pkg::CmdEnd)))
    else $error("end byte malformed");

  // A flush never starts with a wait the full-wait bound cannot cover.
  a_flush_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |=>
      (work_q <= PendW'((MAX_FULL_WAITS + 1) * vgmcse_pkg::FullWait - 1)))
    else $error("flush exceeds full-wait bound");

  // No byte is produced while the divider is still working.
  a_no_emit_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !emit)
    else $error("byte emitted during division");

endmodule
